### sv/minv_pkg.sv
// Package for the modular inverse block: widths, controller commands and status.
package minv_pkg;
    localparam int unsigned WIDTH_DEF = 32;

    typedef struct packed {
        logic load;     // capture operands, start reduction
        logic div_go;   // start a division old_r / r
        logic step;     // apply quotient to coefficient chain
        logic mul_go;   // start q * t multiply
    } minv_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
        logic r_zero;
        logic a_zero;
        logic gcd_one;
    } minv_sts_t;
endpackage

### sv/modular_inverse.sv
// Top level of the modular inverse block (extended Euclid, iterative).
// Operation: a divide reduces the value, then each Euclid step runs a divide
//   and a multiply whose length is set by the quotient length.
// Throughput: one beat at a time; the next input beat is taken after the
//   result beat is accepted. Bit-serial divider and multiplier set the rate.
// Reset: aresetn synchronous active low clears controller and unit busy flags.
module modular_inverse import minv_pkg::*; #(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // value [WIDTH-1:0], modulus [2*WIDTH-2:WIDTH], zero fill to bytes
    input  logic [((2*WIDTH-1+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // inverse [WIDTH-2:0], zero fill to bytes
    output logic [((WIDTH-1+7)/8)*8-1:0] m_tdata,
    // status: 1 = no inverse
    output logic m_tuser
);
    localparam int unsigned OW = ((WIDTH-1+7)/8)*8;
    minv_cmd_t cmd;
    minv_sts_t sts;
    logic ok;
    logic [WIDTH-2:0] inv;

    minv_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .cmd, .sts, .ok
    );

    minv_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .value_in(s_tdata[WIDTH-1:0]),
        .modulus_in(s_tdata[2*WIDTH-2:WIDTH]),
        .inverse_out(inv)
    );

    assign m_tdata = ok ? OW'(inv) : '0;
    assign m_tuser = ~ok;
endmodule

### sv/minv_datapath.sv
// Datapath: operand registers, shift-subtract divider, shift-add multiplier.
module minv_datapath import minv_pkg::*; #(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  minv_cmd_t          cmd,
    output minv_sts_t          sts,
    input  logic [WIDTH-1:0]   value_in,
    input  logic [WIDTH-2:0]   modulus_in,
    output logic [WIDTH-2:0]   inverse_out
);
    localparam int unsigned MW = WIDTH - 1;
    localparam int unsigned CW = $clog2(WIDTH + 1);
    // coefficients stay within +-modulus
    localparam int unsigned TW = WIDTH + 1;

    logic [MW-1:0] m_reg, old_r_reg, r_reg, q_reg;
    logic [MW-1:0] m_next, old_r_next, r_next, q_next;
    logic neg_reg, neg_next, red_reg, red_next;
    logic signed [TW-1:0] old_t_reg, t_reg, old_t_next, t_next;

    // divider: numerator shifted in bit by bit
    logic [WIDTH-1:0] dnum_reg, dnum_next;
    logic [MW:0] drem_reg, drem_next;
    logic [MW-1:0] dden_reg, dden_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic [CW-1:0] dlen_reg, dlen_next;
    logic dbusy_reg, dbusy_next;

    // multiplier: q * t, q bit-serial
    logic [MW-1:0] mq_reg, mq_next;
    logic signed [2*TW-1:0] macc_reg, macc_next, mt_reg, mt_next;
    logic mbusy_reg, mbusy_next;

    logic [MW:0] trial;
    logic [MW:0] drem_sh;

    always_comb begin
        old_r_next = old_r_reg; r_next = r_reg; q_next = q_reg; m_next = m_reg;
        neg_next = neg_reg; red_next = red_reg;
        old_t_next = old_t_reg; t_next = t_reg;
        dnum_next = dnum_reg; drem_next = drem_reg; dden_next = dden_reg;
        dcnt_next = dcnt_reg; dlen_next = dlen_reg; dbusy_next = dbusy_reg;
        mq_next = mq_reg; macc_next = macc_reg; mt_next = mt_reg; mbusy_next = mbusy_reg;
        drem_sh = {drem_reg[MW-1:0], dnum_reg[WIDTH-1]};
        trial = drem_sh - {1'b0, dden_reg};

        if (cmd.load) begin
            m_next = modulus_in;
            neg_next = value_in[WIDTH-1];
            // start reduction: mag % m
            dnum_next = value_in[WIDTH-1] ? (~value_in + 1'b1) : value_in;
            drem_next = '0;
            dden_next = modulus_in;
            dlen_next = CW'(WIDTH);
            dcnt_next = '0;
            dbusy_next = 1'b1;
            red_next = 1'b1;
            old_t_next = '0;
            t_next = TW'(1);
        end else if (cmd.div_go) begin
            dnum_next = {old_r_reg, 1'b0};
            drem_next = '0;
            dden_next = r_reg;
            dlen_next = CW'(MW);
            dcnt_next = '0;
            dbusy_next = 1'b1;
        end else if (dbusy_reg) begin
            if (trial[MW]) begin
                drem_next = drem_sh;
                q_next = {q_reg[MW-2:0], 1'b0};
            end else begin
                drem_next = trial;
                q_next = {q_reg[MW-2:0], 1'b1};
            end
            dnum_next = {dnum_reg[WIDTH-2:0], 1'b0};
            dcnt_next = dcnt_reg + 1'b1;
            if (dcnt_reg == dlen_reg - 1'b1) begin
                dbusy_next = 1'b0;
                if (red_reg) begin
                    red_next = 1'b0;
                    old_r_next = m_reg;
                    if (neg_reg && (trial[MW] ? drem_sh : trial) != '0)
                        r_next = m_reg - MW'(trial[MW] ? drem_sh : trial);
                    else
                        r_next = MW'(trial[MW] ? drem_sh : trial);
                end else begin
                    // remainder kept until step
                    drem_next = trial[MW] ? drem_sh : trial;
                end
            end
        end

        if (cmd.mul_go) begin
            mq_next = q_reg;
            mt_next = (2*TW)'(t_reg);
            macc_next = '0;
            mbusy_next = 1'b1;
        end else if (mbusy_reg) begin
            if (mq_reg[0]) macc_next = macc_reg + mt_reg;
            mq_next = mq_reg >> 1;
            mt_next = mt_reg <<< 1;
            if (mq_reg == '0) mbusy_next = 1'b0;
        end

        if (cmd.step) begin
            old_r_next = r_reg;
            r_next = MW'(drem_reg);
            old_t_next = t_reg;
            t_next = old_t_reg - TW'(macc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        m_reg <= m_next; old_r_reg <= old_r_next; r_reg <= r_next; q_reg <= q_next;
        neg_reg <= neg_next;
        old_t_reg <= old_t_next; t_reg <= t_next;
        dnum_reg <= dnum_next; drem_reg <= drem_next; dden_reg <= dden_next;
        dcnt_reg <= dcnt_next; dlen_reg <= dlen_next;
        mq_reg <= mq_next; macc_reg <= macc_next; mt_reg <= mt_next;
        if (!aresetn) begin
            dbusy_reg <= 1'b0; mbusy_reg <= 1'b0; red_reg <= 1'b0;
        end else begin
            dbusy_reg <= dbusy_next; mbusy_reg <= mbusy_next; red_reg <= red_next;
        end
    end

    assign sts.div_busy = dbusy_reg;
    assign sts.mul_busy = mbusy_reg;
    assign sts.r_zero   = (r_reg == '0);
    assign sts.a_zero   = (m_reg == '0);
    assign sts.gcd_one  = (old_r_reg == MW'(1));
    // old_t within (-m, m): one conditional add normalizes
    assign inverse_out = old_t_reg[TW-1] ? MW'(old_t_reg + TW'(m_reg)) : MW'(old_t_reg);
endmodule

### sv/minv_ctrl.sv
// Controller: sequences reduction, divide, multiply and update steps.
module minv_ctrl import minv_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output minv_cmd_t cmd,
    input  minv_sts_t sts,
    output logic      ok
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_CHK = 3'd2,
                           S_DIV = 3'd3, S_MUL = 3'd4, S_DONE = 3'd5;
    logic [2:0] state_reg, state_next;
    logic ok_reg, ok_next, wait_reg, wait_next;

    always_comb begin
        state_next = state_reg; ok_next = ok_reg; wait_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                cmd.load = 1'b1; wait_next = 1'b1; state_next = S_RED;
            end
            S_RED: if (!wait_reg && !sts.div_busy) begin
                if (sts.a_zero || sts.r_zero) begin
                    ok_next = 1'b0; state_next = S_DONE;
                end else state_next = S_CHK;
            end
            S_CHK: if (sts.r_zero) begin
                ok_next = sts.gcd_one; state_next = S_DONE;
            end else begin
                cmd.div_go = 1'b1; wait_next = 1'b1; state_next = S_DIV;
            end
            S_DIV: if (!wait_reg && !sts.div_busy) begin
                cmd.mul_go = 1'b1; wait_next = 1'b1; state_next = S_MUL;
            end
            S_MUL: if (!wait_reg && !sts.mul_busy) begin
                cmd.step = 1'b1; state_next = S_CHK;
            end
            S_DONE: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; ok_reg <= 1'b0; wait_reg <= 1'b0;
        end else begin
            state_reg <= state_next; ok_reg <= ok_next; wait_reg <= wait_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign ok = ok_reg;
endmodule

### tb/sv/tb_modular_inverse.sv
// Testbench for modular_inverse: stream stimulus, in-bench extended Euclid predictor, checker.
module tb_modular_inverse import minv_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned W = WIDTH_DEF;
    localparam int unsigned SDW = ((2*W-1+7)/8)*8;
    localparam int unsigned MDW = ((W-1+7)/8)*8;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [W-2:0] inverse;
        logic         no_inv;
    } inv_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SDW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MDW-1:0] m_tdata;
    logic m_tuser;

    inv_result_t expected_q[$];
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int no_inv_seen = 0;
    int rdy_hold = 0;
    longint cycles = 0;
    bit stall_enable = 1'b1;

    modular_inverse #(.WIDTH(W)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // cycle counter doubles as a watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("tb: failure");
            $finish;
        end
    end

    // Expected inverse: reduce the signed value, then extended Euclid.
    function automatic inv_result_t predict_inverse(logic [W-1:0] value, logic [W-2:0] modulus);
        inv_result_t res;
        longint unsigned m, a, mag, rr, old_r, r, q, nr;
        longint old_t, t, nt;
        res.inverse = '0;
        res.no_inv = 1'b1;
        m = modulus;
        if (m == 0) return res;
        if (value[W-1]) begin
            mag = (64'd1 << W) - value;
            rr = mag % m;
            a = (rr == 0) ? 0 : m - rr;
        end else begin
            a = value % m;
        end
        if (a == 0) return res;
        old_r = m; r = a; old_t = 0; t = 1;
        while (r != 0) begin
            q = old_r / r;
            nr = old_r - q * r;
            nt = old_t - longint'(q) * t;
            old_r = r; r = nr; old_t = t; t = nt;
        end
        if (old_r != 1) return res;
        if (old_t < 0) old_t += longint'(m);
        res.inverse = (W-1)'($unsigned(old_t) % m);
        res.no_inv = 1'b0;
        return res;
    endfunction

    function automatic int pick_gap();
        if (!stall_enable) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // valid stays up between back-to-back beats; dropped only for a gap
    task automatic send_operands(logic [W-1:0] value, logic [W-2:0] modulus);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        expected_q = {expected_q, predict_inverse(value, modulus)};
        s_tdata <= SDW'({modulus, value});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // result side: random ready stalls, check on each handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            int rgap;
            if (m_tvalid && m_tready) begin
                inv_result_t exp_r;
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result beat inverse=%0d status=%0b",
                             $time, m_tdata[W-2:0], m_tuser);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_tdata[W-2:0] !== exp_r.inverse)
                        $display("%0t inverse mismatch expected %0d actual %0d",
                                 $time, exp_r.inverse, m_tdata[W-2:0]);
                    if (m_tuser !== exp_r.no_inv)
                        $display("%0t status mismatch expected %0b actual %0b",
                                 $time, exp_r.no_inv, m_tuser);
                    if (m_tdata[W-2:0] !== exp_r.inverse || m_tuser !== exp_r.no_inv)
                        errors++;
                    if (exp_r.no_inv) no_inv_seen++;
                end
                beats_checked++;
            end
            if (rdy_hold > 0) begin
                m_tready <= 1'b0;
                rdy_hold <= rdy_hold - 1;
            end else begin
                rgap = pick_gap();
                m_tready <= (rgap == 0);
                rdy_hold <= (rgap == 0) ? 0 : rgap - 1;
            end
        end
    end

    task automatic test_directed();
        logic [W-2:0] mmax;
        mmax = {(W-1){1'b1}};
        send_operands(32'd3, 31'd7);
        send_operands(32'd1, 31'd2);
        send_operands(32'd0, 31'd13);               // residue zero
        send_operands(32'd26, 31'd13);              // multiple of modulus
        send_operands(32'd6, 31'd9);                // gcd not one
        send_operands(-32'sd1, 31'd11);             // negative value
        send_operands(-32'sd22, 31'd11);            // negative multiple
        send_operands(32'h8000_0000, 31'd3);        // most negative value
        send_operands(32'h8000_0000, mmax);
        send_operands(32'h7FFF_FFFF, mmax);         // value equals modulus
        send_operands(32'h7FFF_FFFE, mmax);
        send_operands(32'hFFFF_FFFF, mmax);
        send_operands(32'd2, mmax);
        send_operands(32'd1, mmax);
        send_operands(32'hFFFF_FFFF, 31'd2);
        send_operands(32'd5, 31'd0);                // zero modulus, out of range
        send_operands(32'd1, 31'd1);                // modulus one
        send_operands(32'd1_134_903_170, 31'd1_836_311_903); // adjacent Fibonacci, long chain
        send_operands(32'h5555_5555, 31'h2AAA_AAAB);
        send_operands(32'd12345, 31'd65536);
    endtask

    task automatic test_random(int n);
        logic [W-1:0] v;
        logic [W-2:0] m;
        for (int i = 0; i < n; i++) begin
            v = $urandom();
            case ($urandom_range(0, 3))
                0: m = $urandom_range(2, 100);
                1: m = $urandom_range(2, 65535);
                default: m = (W-1)'($urandom()) | 31'd2;
            endcase
            if (m < 2) m = 2;
            if ($urandom_range(0, 15) == 0) v = m * $urandom_range(0, 5); // small m: residue 0
            stall_enable = (i % 100) >= 20;
            send_operands(v, m);
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d operand beats, %0d results checked, %0d without inverse",
                 beats_sent, beats_checked, no_inv_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
